>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the partitioned Bloom filter block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/pbf_pkg.sv
// Package for the partitioned Bloom filter: default sizes, field widths, reset values,
// register indexes, item codes and the remainder unit request/response types.
// Depends on nothing.
package pbf_pkg;

  // Default sizes of the filter store
  localparam int DEF_MAX_BITS   = 4096;
  localparam int DEF_MAX_REPS   = 8;
  localparam int DEF_MAX_HASHES = 16;

  // Results per item never exceed this count
  localparam int RESULT_CAP = 8;

  // Field widths
  localparam int HASH_W  = 64;
  localparam int HC_W    = 5;
  localparam int PC_W    = 16;
  localparam int FL_W    = 13;
  localparam int RC_W    = 4;
  localparam int RREP_W  = 3;
  localparam int RPOS_W  = 12;
  localparam int OFS_W   = 16;
  localparam int REPI_W  = 3;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register reset values
  localparam logic [HC_W-1:0] HC_RST = 5'd3;
  localparam logic [PC_W-1:0] PC_RST = 16'd1;
  localparam logic [FL_W-1:0] FL_RST = 13'd4096;
  localparam logic [RC_W-1:0] RC_RST = 4'd1;

  // Register indexes (byte address is four times the index)
  typedef enum logic [1:0] {
    REG_HASH_COUNT,
    REG_PARTITION_COUNT,
    REG_FILTER_LENGTH,
    REG_REPETITION_COUNT
  } reg_idx_t;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Remainder unit request: start pulse with operands
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [PC_W-1:0]   divisor;
  } mod_req_t;

  // Remainder unit response: done pulse with result
  typedef struct packed {
    logic            done;
    logic [PC_W-1:0] remainder;
  } mod_rsp_t;

endpackage

>>> sv/pbf_if.sv
// Valid/ready channel interfaces for input items and result beats.
// Depends on pbf_pkg for the field widths.
interface pbf_in_if import pbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [HASH_W-1:0]   word_hash_low;
  logic [HASH_W-1:0]   word_hash_high;
  logic [HASH_W-1:0]   id_hash_low;
  logic [HASH_W-1:0]   id_hash_high;
  logic [RREP_W-1:0]   read_repetition;
  logic [RPOS_W-1:0]   read_position;

  modport source (
    output valid, kind, word_hash_low, word_hash_high, id_hash_low, id_hash_high,
           read_repetition, read_position,
    input  ready
  );
  modport sink (
    input  valid, kind, word_hash_low, word_hash_high, id_hash_low, id_hash_high,
           read_repetition, read_position,
    output ready
  );
endinterface

interface pbf_out_if import pbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OFS_W-1:0]  partition_offset;
  logic [REPI_W-1:0] repetition_index;
  logic              bit_value;
  logic              last;

  modport source (
    output valid, partition_offset, repetition_index, bit_value, last,
    input  ready
  );
  modport sink (
    input  valid, partition_offset, repetition_index, bit_value, last,
    output ready
  );
endinterface

>>> sv/pbf_mod_unit.sv
// Shared remainder unit: 64-bit dividend modulo a 16-bit divisor, one
// quotient bit per cycle (restoring). Depends on pbf_pkg.
module pbf_mod_unit import pbf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(HASH_W);

  logic [HASH_W-1:0] dvd;
  logic [PC_W-1:0]   dsr;
  logic [PC_W-1:0]   rem;
  logic [PC_W-1:0]   rem_next;
  logic [PC_W:0]     trial;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial    = {rem, dvd[HASH_W-1]};
    rem_next = (trial >= {1'b0, dsr}) ? PC_W'(trial - {1'b0, dsr}) : PC_W'(trial);
  end

  // Load on start, then iterate over all dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[HASH_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

>>> sv/partitioned_bloom_filter_insert.sv
// Top level of the partitioned Bloom filter insert block: register port,
// sequencer, bit store and result register. Depends on pbf_pkg, pbf_if,
// pbf_mod_unit and assert_macros.svh.
//
//   channel  | dir | handshake            | beat
//   item     | in  | valid/ready          | kind, four hash halves, read address
//   result   | out | valid/ready          | partition_offset, repetition_index,
//            |     |                      | bit_value, last
//   apb      | in  | psel/penable/pready  | 32-bit register write or read
//
// Every remainder goes through one shared unit, one operation at a time;
// an insert needs 2 + R * (2 + k) of them (R repetitions, k hashes), while
// a read needs none and waits only on the store read and any stall.
// After reset the store is cleared one bit per cycle, MAX_REPS times the
// power of two at or above MAX_BITS bits (32768 at defaults); item.ready
// stays low until then. A stalled result holds the sequencer before its
// next result, and the next item is taken while the last result waits.
`include "assert_macros.svh"

module partitioned_bloom_filter_insert import pbf_pkg::*; #(
  parameter int MAX_BITS   = DEF_MAX_BITS,
  parameter int MAX_REPS   = DEF_MAX_REPS,
  parameter int MAX_HASHES = DEF_MAX_HASHES
) (
  input  logic               clk,
  input  logic               rst,
  pbf_in_if.sink             item,
  pbf_out_if.source          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int PW    = $clog2(MAX_BITS);
  localparam int RW    = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;
  localparam int DEPTH = MAX_REPS * (1 << PW);
  localparam int AW    = $clog2(DEPTH);

  // Caps on the effective register values
  localparam logic [RC_W-1:0] REP_CAP =
    RC_W'((MAX_REPS < RESULT_CAP) ? MAX_REPS : RESULT_CAP);
  localparam logic [HC_W-1:0] HASH_CAP =
    HC_W'((MAX_HASHES < (1 << HC_W) - 1) ? MAX_HASHES : (1 << HC_W) - 1);
  localparam logic [FL_W-1:0] LEN_CAP =
    FL_W'((MAX_BITS < (1 << FL_W) - 1) ? MAX_BITS : (1 << FL_W) - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WA, S_IDB, S_G, S_GM, S_H, S_SET, S_EMIT, S_RD, S_RDOUT
  } state_t;

  // Configuration registers
  logic [HC_W-1:0] hash_count;
  logic [PC_W-1:0] partition_count;
  logic [FL_W-1:0] filter_length;
  logic [RC_W-1:0] repetition_count;

  // Effective values
  logic [HC_W-1:0] k_eff;
  logic [PC_W-1:0] b_eff;
  logic [FL_W-1:0] m_eff;
  logic [RC_W-1:0] reps_eff;

  state_t            state;
  mod_req_t          mreq;
  mod_rsp_t          mrsp;
  logic [HASH_W-1:0] wb;
  logic [HASH_W-1:0] ida;
  logic [HASH_W-1:0] idb;
  logic [HASH_W-1:0] acc_r;
  logic [HASH_W-1:0] acc_i;
  logic [HASH_W-1:0] acc_r_next;
  logic [HASH_W-1:0] acc_i_next;
  logic [FL_W-1:0]   wam;
  logic [PC_W-1:0]   idbm;
  logic [OFS_W-1:0]  g;
  logic [OFS_W-1:0]  g_next;
  logic [FL_W-1:0]   gm;
  logic [FL_W-1:0]   h;
  logic [FL_W-1:0]   h_next;
  logic [FL_W-1:0]   set_pos;
  logic [REPI_W-1:0] r;
  logic [HC_W-1:0]   i;
  logic [RREP_W-1:0] rd_rep;
  logic [RPOS_W-1:0] rd_pos;
  logic              rd_ok;
  logic              rd_ok_next;
  logic [AW-1:0]     clr_addr;
  logic              rep_last;
  logic              hash_last;
  logic              slot_free;
  logic              accept;
  logic              start_now;
  logic              emit_now;

  // Result register
  logic              out_valid;
  logic [OFS_W-1:0]  out_ofs;
  logic [REPI_W-1:0] out_rep;
  logic              out_bit;
  logic              out_last;
  logic              out_is_read;

  // Bit store
  logic              mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic              mem_rdata;

  // Register writes and reads
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count       <= HC_RST;
      partition_count  <= PC_RST;
      filter_length    <= FL_RST;
      repetition_count <= RC_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_HASH_COUNT:       hash_count       <= pwdata[HC_W-1:0];
        REG_PARTITION_COUNT:  partition_count  <= pwdata[PC_W-1:0];
        REG_FILTER_LENGTH:    filter_length    <= pwdata[FL_W-1:0];
        REG_REPETITION_COUNT: repetition_count <= pwdata[RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_HASH_COUNT:       prdata = PDATA_W'(hash_count);
      REG_PARTITION_COUNT:  prdata = PDATA_W'(partition_count);
      REG_FILTER_LENGTH:    prdata = PDATA_W'(filter_length);
      REG_REPETITION_COUNT: prdata = PDATA_W'(repetition_count);
      default:              prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Saturate registers to their legal ranges
  always_comb begin
    k_eff    = (hash_count == '0) ? HC_W'(1) :
               (hash_count > HASH_CAP) ? HASH_CAP : hash_count;
    b_eff    = (partition_count == '0) ? PC_W'(1) : partition_count;
    m_eff    = (filter_length == '0) ? FL_W'(1) :
               (filter_length > LEN_CAP) ? LEN_CAP : filter_length;
    reps_eff = (repetition_count == '0) ? RC_W'(1) :
               (repetition_count > REP_CAP) ? REP_CAP : repetition_count;
  end

  // Datapath around the remainder unit
  logic [OFS_W:0]  g_sum;
  logic [FL_W:0]   h_sum;
  logic [FL_W:0]   p_sum;
  always_comb begin
    g_sum      = {1'b0, mrsp.remainder} + {1'b0, idbm};
    g_next     = (g_sum >= {1'b0, b_eff}) ? OFS_W'(g_sum - {1'b0, b_eff}) : OFS_W'(g_sum);
    h_sum      = {1'b0, wam} + {1'b0, FL_W'(mrsp.remainder)};
    h_next     = (h_sum >= {1'b0, m_eff}) ? FL_W'(h_sum - {1'b0, m_eff}) : FL_W'(h_sum);
    p_sum      = {1'b0, h} + {1'b0, gm};
    set_pos    = (p_sum >= {1'b0, m_eff}) ? FL_W'(p_sum - {1'b0, m_eff}) : FL_W'(p_sum);
    acc_r_next = acc_r + ida;
    acc_i_next = acc_i + wb;
    rep_last   = ({1'b0, r} + 4'd1) == reps_eff;
    hash_last  = ({1'b0, i} + 6'd1) == {1'b0, k_eff};
    slot_free  = !out_valid || result.ready;
    accept     = item.valid && item.ready;
    emit_now   = ((state == S_EMIT) || (state == S_RDOUT)) && slot_free;
    rd_ok_next = ({1'b0, item.read_repetition} < reps_eff) &&
                 ({1'b0, item.read_position} < m_eff);
  end

  // Issue a remainder request whenever a step hands the unit new operands
  always_comb begin
    case (state)
      S_IDLE:                 start_now = accept && (item.kind == KIND_INSERT);
      S_WA, S_IDB, S_G, S_GM: start_now = mrsp.done;
      S_SET:                  start_now = !hash_last;
      S_EMIT:                 start_now = slot_free && !rep_last;
      default:                start_now = 1'b0;
    endcase
  end

  assign item.ready = (state == S_IDLE);

  // Sequencer with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      mreq.start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      mreq.start <= start_now;
      out_valid  <= emit_now || (out_valid && !result.ready);
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            wb     <= item.word_hash_high;
            ida    <= item.id_hash_low;
            idb    <= item.id_hash_high;
            rd_rep <= item.read_repetition;
            rd_pos <= item.read_position;
            rd_ok  <= rd_ok_next;
            acc_r  <= '0;
            acc_i  <= '0;
            r      <= '0;
            if (item.kind == KIND_READ) begin
              state <= S_RD;
            end else begin
              mreq.dividend <= item.word_hash_low;
              mreq.divisor  <= PC_W'(m_eff);
              state         <= S_WA;
            end
          end
        end
        S_WA: begin
          if (mrsp.done) begin
            wam           <= FL_W'(mrsp.remainder);
            mreq.dividend <= idb;
            mreq.divisor  <= b_eff;
            state         <= S_IDB;
          end
        end
        S_IDB: begin
          if (mrsp.done) begin
            idbm          <= mrsp.remainder;
            mreq.dividend <= acc_r;
            mreq.divisor  <= b_eff;
            state         <= S_G;
          end
        end
        S_G: begin
          if (mrsp.done) begin
            g             <= g_next;
            acc_i         <= '0;
            i             <= '0;
            mreq.dividend <= HASH_W'(g_next);
            mreq.divisor  <= PC_W'(m_eff);
            state         <= S_GM;
          end
        end
        S_GM: begin
          if (mrsp.done) begin
            gm            <= FL_W'(mrsp.remainder);
            mreq.dividend <= acc_i;
            mreq.divisor  <= PC_W'(m_eff);
            state         <= S_H;
          end
        end
        S_H: begin
          if (mrsp.done) begin
            h     <= h_next;
            state <= S_SET;
          end
        end
        S_SET: begin
          // Bit is written by the store below; advance to the next hash
          acc_i <= acc_i_next;
          i     <= i + 1'b1;
          if (hash_last) begin
            state <= S_EMIT;
          end else begin
            mreq.dividend <= acc_i_next;
            mreq.divisor  <= PC_W'(m_eff);
            state         <= S_H;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_ofs     <= g;
            out_rep     <= r;
            out_bit     <= 1'b0;
            out_last    <= rep_last;
            out_is_read <= 1'b0;
            if (rep_last) begin
              state <= S_IDLE;
            end else begin
              r             <= r + 1'b1;
              acc_r         <= acc_r_next;
              mreq.dividend <= acc_r_next;
              mreq.divisor  <= b_eff;
              state         <= S_G;
            end
          end
        end
        S_RD: begin
          state <= S_RDOUT;
        end
        S_RDOUT: begin
          if (slot_free) begin
            out_ofs     <= '0;
            out_rep     <= rd_rep;
            out_bit     <= rd_ok && mem_rdata;
            out_last    <= 1'b1;
            out_is_read <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Store write port: clearing sweep or setting one bit
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_SET);
    mem_wdata = (state == S_SET);
    mem_waddr = (state == S_CLEAR) ? clr_addr : AW'({RW'(r), PW'(set_pos)});
    mem_raddr = AW'({RW'(rd_rep), PW'(rd_pos)});
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  pbf_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign result.valid            = out_valid;
  assign result.partition_offset = out_ofs;
  assign result.repetition_index = out_rep;
  assign result.bit_value        = out_bit;
  assign result.last             = out_last;

  // Sequencer leaves idle once an item is taken
  `ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !item.ready)
  // Set bits stay inside the configured arrays
  `ASSERT_IMP(a_set_in_range, clk, rst, state == S_SET,
              (set_pos < m_eff) && ({1'b0, r} < reps_eff))
  // Final insert result belongs to the last repetition
  `ASSERT_IMP(a_last_rep, clk, rst, out_valid && out_last && !out_is_read,
              {1'b0, out_rep} == (reps_eff - 4'd1))
  // Remainder unit answers only while the sequencer waits for it
  `ASSERT_IMP(a_done_expected, clk, rst, mrsp.done,
              state == S_WA || state == S_IDB || state == S_G || state == S_GM ||
              state == S_H)

endmodule
